[sv/hwr_pkg.sv]
// ----------------------------------------------------------------------------
// Hit window readout package
// Beat types and fixed constants shared by the readout, its checker and testbench.
// ----------------------------------------------------------------------------
package hwr_pkg;

  localparam int unsigned ADDR_IN_W = 6;
  localparam int unsigned HIT_W     = 48;
  localparam int unsigned TAG_W     = 4;
  localparam int unsigned OFFSET_W  = 11;
  localparam int unsigned WORD_W    = 32;

  localparam logic ACT_STORE   = 1'b0;
  localparam logic ACT_TRIGGER = 1'b1;

  localparam logic [WORD_W-1:0] TRAILER_WORD = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                 action;
    logic [ADDR_IN_W-1:0] entry_addr;
    logic [HIT_W-1:0]     entry_value;
    logic [ADDR_IN_W-1:0] window_start;
    logic [ADDR_IN_W-1:0] window_stop;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_head;
    logic [WORD_W-1:0] word_upper;
    logic [WORD_W-1:0] word_lower;
    logic              end_marker;
  } out_item_t;

endpackage

[sv/hwr_ram.sv]
// ----------------------------------------------------------------------------
// Hit window readout RAM
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hwr_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/hit_window_readout.sv]
// ----------------------------------------------------------------------------
// Hit window readout
// Circular hit buffer with a windowed trigger readout and trailer beat.
// ----------------------------------------------------------------------------
// After reset the buffer is cleared one entry per cycle, so busy stays high
// until the clear ends; no beat is taken before. A store beat leaves the
// readout idle. A trigger beat scans one buffer address per cycle through
// the single read port of the buffer RAM and keeps busy high through the
// scan and the trailer; results appear on out_strobe for one cycle each
// and cannot be held off, so the receiver must take every beat.
module hit_window_readout
  import hwr_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_strobe,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [TAG_W-1:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TRAIL
  } state_t;

  function automatic logic [AW-1:0] reduce_addr(input logic [ADDR_IN_W-1:0] a);
    logic [AW-1:0] r;
    r = '0;
    for (int i = 0; i < 2 ** ADDR_IN_W; i++) begin
      if (a == ADDR_IN_W'(i)) begin
        r = AW'(i % BUFFER_DEPTH);
      end
    end
    return r;
  endfunction

  state_t              state_r, state_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [AW-1:0]       stop_r, stop_nxt;
  logic [OFFSET_W-1:0] steps_r, steps_nxt;
  logic [OFFSET_W-1:0] pend_off_r, pend_off_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [TAG_W-1:0]    tag_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic                accept;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [HIT_W-1:0]    wr_data;
  logic                rd_en;
  logic [HIT_W-1:0]    rd_data;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_valid_r;
  assign out_item   = out_item_r;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = addr_r;
      wr_data = '0;
    end else begin
      wr_en   = accept && (in_item.action == ACT_STORE);
      wr_addr = reduce_addr(in_item.entry_addr);
      wr_data = in_item.entry_value;
    end
  end

  assign rd_en = (state_r == ST_SCAN) && (addr_r != stop_r);

  hwr_ram #(
    .WIDTH (HIT_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_hit_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    stop_nxt      = stop_r;
    steps_nxt     = steps_r;
    pend_off_nxt  = pend_off_r;
    rd_pend_nxt   = 1'b0;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    if (rd_pend_r && (rd_data != '0)) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.word_head  = {1'b1, tag_r, pend_off_r, 16'h0000};
      out_item_nxt.word_upper = {15'h0000, rd_data[47:31]};
      out_item_nxt.word_lower = {1'b0, rd_data[30:0]};
      out_item_nxt.end_marker = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept && (in_item.action == ACT_TRIGGER)) begin
          addr_nxt  = reduce_addr(in_item.window_start);
          stop_nxt  = reduce_addr(in_item.window_stop);
          steps_nxt = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr_r != stop_r) begin
          rd_pend_nxt  = 1'b1;
          pend_off_nxt = steps_r;
          steps_nxt    = steps_r + OFFSET_W'(1);
          addr_nxt     = (addr_r == LAST_ADDR) ? '0 : addr_r + AW'(1);
        end else begin
          state_nxt = ST_TRAIL;
        end
      end
      ST_TRAIL: begin
        out_valid_nxt           = 1'b1;
        out_item_nxt.word_head  = TRAILER_WORD;
        out_item_nxt.word_upper = '0;
        out_item_nxt.word_lower = '0;
        out_item_nxt.end_marker = 1'b1;
        state_nxt               = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      tag_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tag_r <= cfg_wdata;
      end
    end
    stop_r     <= stop_nxt;
    steps_r    <= steps_nxt;
    pend_off_r <= pend_off_nxt;
    out_item_r <= out_item_nxt;
  end

  // The trailer closes an event; nothing follows it in the next cycle.
  a_trailer_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.end_marker) |=> !out_strobe)
    else $error("result beat directly after trailer");

  // A beat is taken only when the previous event has fully drained.
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_strobe)
    else $error("result beat right after an accepted beat");

  // Read data is consumed only while a scan is in progress.
  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_SCAN || state_r == ST_TRAIL))
    else $error("pending read outside of a scan");

endmodule

[verif/hwr_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hit window readout checker
// Watches the beat, result and tag ports of the readout and keeps its own
// copy of the hit buffer and the tag. Each accepted trigger beat is turned
// into the hit and trailer beats the readout must produce. Each result beat
// is compared field by field with the oldest of those.
// ----------------------------------------------------------------------------
module hwr_checker
  import hwr_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_item_t         in_item,
  input  logic             out_strobe,
  input  out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [TAG_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending_count
);

  logic [HIT_W-1:0] hit_copy [BUFFER_DEPTH];
  logic [TAG_W-1:0] tag_copy;
  out_item_t        pending_readout [$];
  int               mismatches;

  task automatic scan_window(input in_item_t b);
    int unsigned      addr;
    int unsigned      end_addr;
    int unsigned      steps;
    logic [HIT_W-1:0] v;
    out_item_t        r;
    addr     = b.window_start % BUFFER_DEPTH;
    end_addr = b.window_stop % BUFFER_DEPTH;
    steps    = 0;
    while (addr != end_addr && steps < BUFFER_DEPTH) begin
      v = hit_copy[addr];
      if (v != '0) begin
        r.word_head  = {1'b1, tag_copy, steps[OFFSET_W-1:0], 16'h0000};
        r.word_upper = {15'd0, v[47:31]};
        r.word_lower = {1'b0, v[30:0]};
        r.end_marker = 1'b0;
        pending_readout.push_back(r);
      end
      addr = (addr + 1) % BUFFER_DEPTH;
      steps++;
    end
    r.word_head  = TRAILER_WORD;
    r.word_upper = '0;
    r.word_lower = '0;
    r.end_marker = 1'b1;
    pending_readout.push_back(r);
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (pending_readout.size() == 0) begin
      $error("result beat with no expectation waiting: head %h", got.word_head);
      mismatches++;
    end else begin
      want = pending_readout.pop_front();
      if (got.word_head !== want.word_head) begin
        $error("word_head mismatch: expected %h, actual %h", want.word_head, got.word_head);
        mismatches++;
      end
      if (got.word_upper !== want.word_upper) begin
        $error("word_upper mismatch: expected %h, actual %h", want.word_upper,
               got.word_upper);
        mismatches++;
      end
      if (got.word_lower !== want.word_lower) begin
        $error("word_lower mismatch: expected %h, actual %h", want.word_lower,
               got.word_lower);
        mismatches++;
      end
      if (got.end_marker !== want.end_marker) begin
        $error("end_marker mismatch: expected %b, actual %b", want.end_marker,
               got.end_marker);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
        hit_copy[i] = '0;
      end
      tag_copy = '0;
      pending_readout.delete();
      mismatches = 0;
    end else begin
      if (out_strobe) begin
        compare_result(out_item);
      end
      if (cfg_we) begin
        tag_copy = cfg_wdata;
      end
      if (start && !busy) begin
        if (in_item.action == ACT_STORE) begin
          hit_copy[in_item.entry_addr % BUFFER_DEPTH] = in_item.entry_value;
        end else begin
          scan_window(in_item);
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= pending_readout.size();
  end

endmodule

[verif/hit_window_readout_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hit window readout testbench
// Drives store and trigger beats in random bursts, starting with directed
// windows over a few known hits and then random traffic under several tag
// settings. The checker beside the readout predicts and compares results.
// ----------------------------------------------------------------------------
module hit_window_readout_tb;
  import hwr_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          PHASE_BEATS = 80;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_item;
  logic             out_strobe;
  out_item_t        out_item;
  logic             cfg_we;
  logic [TAG_W-1:0] cfg_wdata;
  int               fail_count;
  int               pending_count;
  int               idle_cycles;
  in_item_t         beat_q [$];
  logic [TAG_W-1:0] phase_tags [4];

  hit_window_readout #(
    .BUFFER_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  hwr_checker #(
    .BUFFER_DEPTH(DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_strobe   (out_strobe),
    .out_item     (out_item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [HIT_W-1:0] rand_hit();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[HIT_W-1:0];
  endfunction

  function automatic in_item_t store_beat(input int unsigned addr,
                                          input logic [HIT_W-1:0] value);
    in_item_t b;
    b.action       = ACT_STORE;
    b.entry_addr   = addr[ADDR_IN_W-1:0];
    b.entry_value  = value;
    b.window_start = ADDR_IN_W'($urandom());
    b.window_stop  = ADDR_IN_W'($urandom());
    return b;
  endfunction

  function automatic in_item_t trigger_beat(input int unsigned first,
                                            input int unsigned last);
    in_item_t b;
    b.action       = ACT_TRIGGER;
    b.entry_addr   = ADDR_IN_W'($urandom());
    b.entry_value  = rand_hit();
    b.window_start = first[ADDR_IN_W-1:0];
    b.window_stop  = last[ADDR_IN_W-1:0];
    return b;
  endfunction

  function automatic in_item_t random_beat();
    int unsigned      first;
    int unsigned      span;
    int unsigned      pick;
    logic [HIT_W-1:0] value;
    pick = $urandom_range(0, 15);
    if (pick < 4) begin
      first = $urandom_range(0, DEPTH - 1);
      case ($urandom_range(0, 5))
        0:       span = 0;
        1:       span = DEPTH - 1;
        default: span = $urandom_range(0, DEPTH - 1);
      endcase
      return trigger_beat(first, (first + span) % DEPTH);
    end
    case ($urandom_range(0, 7))
      0:       value = '0;
      1:       value = '1;
      2:       value = {{(HIT_W-1){1'b0}}, 1'b1} << $urandom_range(0, HIT_W - 1);
      default: value = rand_hit();
    endcase
    return store_beat($urandom_range(0, DEPTH - 1), value);
  endfunction

  task automatic drive_beat(input in_item_t b);
    start   <= 1'b1;
    in_item <= b;
    do @(posedge clk); while (busy);
  endtask

  task automatic run_beat_q();
    int burst_len;
    int gap_len;
    while (beat_q.size() > 0) begin
      burst_len = $urandom_range(1, 12);
      while (burst_len > 0 && beat_q.size() > 0) begin
        drive_beat(beat_q.pop_front());
        burst_len--;
      end
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap_len > 0) begin
        start <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    start <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_tag(input logic [TAG_W-1:0] tag);
    cfg_we    <= 1'b1;
    cfg_wdata <= tag;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    idle_cycles <= 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    wait_idle();

    // Empty buffer first, then a few hits at the edges of the word split.
    beat_q.push_back(trigger_beat(0, 0));
    beat_q.push_back(trigger_beat(0, 63));
    beat_q.push_back(store_beat(0, '1));
    beat_q.push_back(store_beat(63, 48'h0000_0000_0001));
    beat_q.push_back(store_beat(31, 48'h0000_8000_0000));
    beat_q.push_back(store_beat(32, 48'h0000_7FFF_FFFF));
    beat_q.push_back(store_beat(1, '0));
    beat_q.push_back(trigger_beat(0, 0));
    beat_q.push_back(trigger_beat(63, 1));
    beat_q.push_back(trigger_beat(0, 63));
    beat_q.push_back(trigger_beat(1, 0));
    beat_q.push_back(trigger_beat(63, 63));
    beat_q.push_back(trigger_beat(31, 33));
    run_beat_q();
    wait_idle();

    write_tag(4'hF);
    beat_q.push_back(store_beat(0, '0));
    beat_q.push_back(trigger_beat(63, 62));
    beat_q.push_back(store_beat(62, 48'h8000_0000_0000));
    beat_q.push_back(store_beat(17, 48'h5555_AAAA_5555));
    beat_q.push_back(trigger_beat(62, 0));
    beat_q.push_back(trigger_beat(16, 18));
    run_beat_q();
    wait_idle();

    phase_tags[0] = 4'h0;
    phase_tags[1] = TAG_W'($urandom());
    phase_tags[2] = 4'hF;
    phase_tags[3] = TAG_W'($urandom());
    for (int p = 0; p < 4; p++) begin
      write_tag(phase_tags[p]);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        beat_q.push_back(random_beat());
      end
      run_beat_q();
      wait_idle();
    end

    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
